/* rtl/note_name_to_midi_parser_core_macros.svh */
// Assertion macros for the note name parser.
`ifndef NOTE_NAME_TO_MIDI_PARSER_CORE_MACROS_SVH
`define NOTE_NAME_TO_MIDI_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NNMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NNMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nnmp_pkg.sv */
// Types, character codes and helpers shared by the note name parser.
package nnmp_pkg;

    typedef enum logic [1:0] {
        PH_LETTER,
        PH_ACCID,
        PH_OCTAVE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic signed [7:0]  pitch;
        logic [7:0]         octave;
        logic               negative;
    } parse_state_t;

    typedef struct packed {
        logic       emit;
        logic       bad;
        logic [6:0] note;
    } step_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] pitch;
    } letter_t;

    localparam logic [15:0] CHAR_NUL     = 16'h0000;
    localparam logic [15:0] CHAR_SPACE   = 16'h0020;
    localparam logic [15:0] CHAR_HASH    = 16'h0023;
    localparam logic [15:0] CHAR_MINUS   = 16'h002D;
    localparam logic [15:0] CHAR_ZERO    = 16'h0030;
    localparam logic [15:0] CHAR_NINE    = 16'h0039;
    localparam logic [15:0] CHAR_LOWER_B = 16'h0062;

    localparam logic signed [7:0] PITCH_MAX  = 8'sd127;
    localparam logic signed [7:0] PITCH_MIN  = -8'sd127;
    localparam logic [7:0]        OCTAVE_MAX = 8'd255;
    localparam logic [6:0]        NOTE_MAX   = 7'd127;

    localparam logic signed [5:0] OFFSET_RESET = -6'sd12;

    localparam parse_state_t STATE_RESET = '{
        phase:    PH_LETTER,
        pitch:    8'sd0,
        octave:   8'd0,
        negative: 1'b0
    };

    function automatic letter_t letter_pitch(input logic [15:0] c);
        letter_t r;
        r = '{valid: 1'b1, pitch: 4'd0};
        unique case (c)
            16'h0043, 16'h0063: r.pitch = 4'd0;
            16'h0044, 16'h0064: r.pitch = 4'd2;
            16'h0045, 16'h0065: r.pitch = 4'd4;
            16'h0046, 16'h0066: r.pitch = 4'd5;
            16'h0047, 16'h0067: r.pitch = 4'd7;
            16'h0041, 16'h0061: r.pitch = 4'd9;
            16'h0042, 16'h0062: r.pitch = 4'd11;
            default:            r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/nnmp_step.sv */
// Per-character parse step: next parse state and the result it may give.
module nnmp_step (
    input  nnmp_pkg::parse_state_t cur_state,
    input  logic [15:0]            char_code,
    input  logic                   first_char,
    input  logic signed [5:0]      note_offset,
    output nnmp_pkg::parse_state_t next_state,
    output nnmp_pkg::step_result_t result
);

    nnmp_pkg::parse_state_t st;
    nnmp_pkg::letter_t      letter;
    logic                   is_digit;
    logic                   is_space;
    logic                   in_octave;
    logic [11:0]            oct12;
    logic signed [13:0]     oct_signed;
    logic signed [13:0]     note_full;
    logic [11:0]            oct_acc;

    assign st       = first_char ? nnmp_pkg::STATE_RESET : cur_state;
    assign letter   = nnmp_pkg::letter_pitch(char_code);
    assign is_digit = (char_code >= nnmp_pkg::CHAR_ZERO) && (char_code <= nnmp_pkg::CHAR_NINE);
    assign is_space = (char_code == nnmp_pkg::CHAR_SPACE);

    // octave * 12 and signed note
    assign oct12      = {1'b0, st.octave, 3'b000} + {2'b00, st.octave, 2'b00};
    assign oct_signed = st.negative ? -$signed({2'b00, oct12}) : $signed({2'b00, oct12});
    assign note_full  = oct_signed + {{6{st.pitch[7]}}, st.pitch}
                      - {{8{note_offset[5]}}, note_offset};

    // octave * 10 + digit
    assign oct_acc = {1'b0, st.octave, 3'b000} + {3'b000, st.octave, 1'b0}
                   + {8'd0, char_code[3:0]};

    always_comb
    begin
        next_state = st;
        result     = '{emit: 1'b0, bad: 1'b0, note: 7'd0};
        in_octave  = 1'b0;

        unique case (st.phase)
            nnmp_pkg::PH_LETTER:
            begin
                if (!is_space)
                begin
                    if (letter.valid)
                    begin
                        next_state.pitch = $signed({4'b0000, letter.pitch});
                        next_state.phase = nnmp_pkg::PH_ACCID;
                    end
                    else
                    begin
                        result.emit = 1'b1;
                        result.bad  = 1'b1;
                    end
                end
            end
            nnmp_pkg::PH_ACCID:
            begin
                priority if (is_space)
                begin
                end
                else if (char_code == nnmp_pkg::CHAR_HASH)
                begin
                    if (st.pitch < nnmp_pkg::PITCH_MAX)
                        next_state.pitch = st.pitch + 8'sd1;
                end
                else if (char_code == nnmp_pkg::CHAR_LOWER_B)
                begin
                    if (st.pitch > nnmp_pkg::PITCH_MIN)
                        next_state.pitch = st.pitch - 8'sd1;
                end
                else if (char_code == nnmp_pkg::CHAR_MINUS || is_digit)
                begin
                    next_state.phase = nnmp_pkg::PH_OCTAVE;
                    in_octave        = 1'b1;
                end
                else
                begin
                    result.emit = 1'b1;
                    result.bad  = 1'b1;
                end
            end
            nnmp_pkg::PH_OCTAVE:
                in_octave = 1'b1;
            nnmp_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (in_octave)
        begin
            priority if (is_space || char_code == nnmp_pkg::CHAR_NUL)
            begin
                result.emit = 1'b1;
                if (note_full < 14'sd0 || note_full > $signed({7'd0, nnmp_pkg::NOTE_MAX}))
                    result.bad = 1'b1;
                else
                    result.note = note_full[6:0];
            end
            else if (char_code == nnmp_pkg::CHAR_MINUS)
                next_state.negative = 1'b1;
            else if (is_digit)
                next_state.octave = (oct_acc > {4'd0, nnmp_pkg::OCTAVE_MAX})
                                  ? nnmp_pkg::OCTAVE_MAX : oct_acc[7:0];
            else
            begin
                result.emit = 1'b1;
                result.bad  = 1'b1;
            end
        end

        if (result.emit)
            next_state.phase = nnmp_pkg::PH_DONE;
    end

endmodule

/* rtl/note_name_to_midi_parser_core.sv */
// Note name parser: stream of characters in, MIDI note numbers out.
// Path: each word is held in the input register, and its result in the result register.
// Throughput: 1 word per cycle while the output is not stalled, set by the
// combinational parse step between the input register and the result register.
// Reset: async active low; parse state to letter phase, note_offset to -12.
// Reset clears both register stages, so no word or result survives it.
`include "note_name_to_midi_parser_core_macros.svh"

module note_name_to_midi_parser_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] char_code
    input  logic        s_axis_tuser,   // [0] first_char

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] note_number, [7] zero
    output logic        m_axis_tuser,   // [0] invalid

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // [5:0] note_offset
);

    logic                   in_valid_reg;
    logic [15:0]            in_char_reg;
    logic                   in_first_reg;
    logic                   out_valid_reg;
    logic [6:0]             out_note_reg;
    logic                   out_invalid_reg;
    logic signed [5:0]      offset_reg;
    nnmp_pkg::parse_state_t state_reg;
    nnmp_pkg::parse_state_t state_next;
    nnmp_pkg::step_result_t step_res;
    logic                   out_free;
    logic                   proc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || proc;
    assign cfg_ready     = 1'b1;

    nnmp_step u_step (
        .cur_state   (state_reg),
        .char_code   (in_char_reg),
        .first_char  (in_first_reg),
        .note_offset (offset_reg),
        .next_state  (state_next),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= nnmp_pkg::STATE_RESET;
            offset_reg    <= nnmp_pkg::OFFSET_RESET;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (proc)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= proc && step_res.emit;
            if (cfg_valid && cfg_ready)
                offset_reg <= $signed(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
        if (proc && step_res.emit)
        begin
            out_note_reg    <= step_res.note;
            out_invalid_reg <= step_res.bad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_note_reg};
    assign m_axis_tuser  = out_invalid_reg;

    `NNMP_ASSERT_IMP(a_bad_note_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[6:0] == 7'd0, "invalid result carries a nonzero note")
    `NNMP_ASSERT_NXT(a_emit_to_done, proc && step_res.emit, state_reg.phase == nnmp_pkg::PH_DONE, "result given but parser not done")
    `NNMP_ASSERT_IMP(a_done_silent, proc && !in_first_reg && state_reg.phase == nnmp_pkg::PH_DONE, !step_res.emit, "result given in done phase")
    `NNMP_ASSERT_IMP(a_pitch_range, 1'b1, state_reg.pitch != -8'sd128, "pitch accumulator out of range")
    `NNMP_ASSERT_NXT(a_no_drop, proc && step_res.emit, m_axis_tvalid, "result lost on its way out")

endmodule
